### rtl/best_fit_region_allocator_assert.svh
// Assertion macros shared by the allocator checker
`ifndef BEST_FIT_REGION_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_REGION_ALLOCATOR_ASSERT_SVH
// Assert that an antecedent implies a consequent on the same edge
`define BFRA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert that an antecedent implies a consequent on the next edge
`define BFRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/bfra_pkg.sv
// Package of types and constants for the best-fit region allocator
`default_nettype none
package bfra_pkg;
  localparam int TableEntries = 16;
  localparam int WordBytes    = 4;
  localparam int SlotCount    = TableEntries - 2;
  localparam int IdxW         = $clog2(SlotCount);
  localparam int CntW         = $clog2(SlotCount + 1);
  localparam int WbW          = (WordBytes > 1) ? $clog2(WordBytes) : 1;

  localparam logic [1:0] ReqHeap  = 2'd0;
  localparam logic [1:0] ReqStack = 2'd1;
  localparam logic [1:0] ReqFree  = 2'd2;

  localparam logic CfgHeapBottom = 1'b0;
  localparam logic CfgHeapTop    = 1'b1;

  // Datapath operations requested by the controller
  typedef enum logic [2:0] {
    OpNone  = 3'd0,
    OpLoad  = 3'd1,
    OpScan  = 3'd2,
    OpPlace = 3'd3,
    OpShift = 3'd4,
    OpDone  = 3'd5
  } op_e;

  typedef struct packed {
    op_e op;
  } bfra_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic shift_last;
    logic fail_early;
    logic found;
    logic is_free;
  } bfra_sts_t;
endpackage
`default_nettype wire

### rtl/bfra_ctrl.sv
// Controller state machine that sequences one request through the datapath
`default_nettype none
module bfra_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  req_valid_i,
  output logic                 req_ready_o,
  output logic                 res_valid_o,
  input  wire                  res_ready_i,
  output bfra_pkg::bfra_cmd_t  cmd_o,
  input  wire bfra_pkg::bfra_sts_t sts_i
);
  import bfra_pkg::*;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StScan  = 5'b00010,
    StPlace = 5'b00100,
    StShift = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   res_valid_q, res_valid_d;

  // Accept a new request in idle once the result register is free
  assign req_ready_o = (state_q == StIdle) && !res_valid_q;
  assign res_valid_o = res_valid_q;

  // Step through scan, placement and table shift
  always_comb begin
    state_d     = state_q;
    res_valid_d = res_valid_q;
    cmd_o.op    = OpNone;
    if (res_valid_q && res_ready_i) res_valid_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (req_valid_i && req_ready_o) begin
          cmd_o.op = OpLoad;
          state_d  = StScan;
        end
      end
      StScan: begin
        cmd_o.op = OpScan;
        if (sts_i.fail_early) begin
          state_d = StOut;
        end else if (sts_i.scan_last) begin
          state_d = StPlace;
        end
      end
      StPlace: begin
        cmd_o.op = OpPlace;
        state_d  = sts_i.found ? StShift : StOut;
      end
      StShift: begin
        cmd_o.op = OpShift;
        if (sts_i.shift_last) state_d = StOut;
      end
      StOut: begin
        cmd_o.op    = OpDone;
        res_valid_d = 1'b1;
        state_d     = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Hold state and result flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end
endmodule
`default_nettype wire

### rtl/bfra_dp.sv
// Datapath: region table, gap scan, placement and table shift
`default_nettype none
module bfra_dp (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire                  cfg_index_i,
  input  wire [31:0]           cfg_data_i,
  input  wire [1:0]            req_type_i,
  input  wire [31:0]           req_size_i,
  input  wire [31:0]           req_address_i,
  input  wire bfra_pkg::bfra_cmd_t cmd_i,
  output bfra_pkg::bfra_sts_t  sts_o,
  output logic [31:0]          grant_address_o,
  output logic                 success_o
);
  import bfra_pkg::*;

  logic [31:0] start_q [SlotCount];
  logic [31:0] len_q   [SlotCount];
  logic [CntW-1:0] count_q;
  logic [31:0] bottom_q, top_q;

  logic [1:0]  type_q;
  logic [32:0] need_q;
  logic [31:0] addr_q;
  logic [CntW-1:0] k_q;
  logic [32:0] lo_end_q;
  logic        found_q;
  logic [32:0] best_gap_q, best_base_q;
  logic [31:0] grant_q;
  logic        ok_q;

  logic [IdxW-1:0] k_idx, km1_idx, kp1_idx;
  logic [31:0] next_start, cur_start, cur_len;
  logic [32:0] gap, need_rnd;
  logic        in_table, fits;
  logic [32:0] place;

  assign k_idx   = k_q[IdxW-1:0];
  assign km1_idx = IdxW'(k_q - CntW'(1));
  assign kp1_idx = IdxW'(k_q + CntW'(1));
  assign in_table  = (k_q < count_q);
  assign cur_start = start_q[k_idx];
  assign cur_len   = len_q[k_idx];
  assign next_start = in_table ? cur_start : top_q;
  assign gap  = (lo_end_q > {1'b0, next_start}) ? 33'd0 : ({1'b0, next_start} - lo_end_q);
  assign fits = (need_q <= gap) && (!found_q || gap < best_gap_q);

  // Round the size up to whole words
  always_comb begin
    need_rnd = {1'b0, req_size_i};
    if (req_size_i[WbW-1:0] != '0 && WordBytes > 1) begin
      need_rnd = {1'b0, req_size_i} + 33'(WordBytes) - 33'(req_size_i[WbW-1:0]);
    end
    if (WordBytes == 1) need_rnd = {1'b0, req_size_i};
  end

  assign place = (type_q == ReqStack) ? (best_base_q + best_gap_q - need_q) : best_base_q;

  // Status for the controller
  always_comb begin
    sts_o.is_free    = (type_q == ReqFree);
    sts_o.found      = found_q;
    sts_o.fail_early = 1'b0;
    sts_o.scan_last  = 1'b0;
    if (type_q == ReqFree) begin
      sts_o.scan_last = (!in_table) || (cur_start == addr_q);
    end else if (type_q == ReqHeap || type_q == ReqStack) begin
      sts_o.fail_early = (need_q == '0) || (count_q >= CntW'(SlotCount)) || need_q[32];
      sts_o.scan_last  = (k_q == count_q);
    end else begin
      sts_o.fail_early = 1'b1;
    end
    if (type_q == ReqFree) begin
      sts_o.shift_last = (k_q + CntW'(1) >= count_q);
    end else begin
      // The new block is written on the step where no lower neighbour starts above it
      sts_o.shift_last = (k_q == '0) || (start_q[km1_idx] <= addr_q);
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bottom_q <= '0;
      top_q    <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgHeapBottom) bottom_q <= cfg_data_i;
      else top_q <= cfg_data_i;
    end
  end

  // Advance the sequence one step per command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ok_q    <= 1'b0;
      grant_q <= '0;
    end else begin
      unique case (cmd_i.op)
        OpLoad: begin
          type_q      <= req_type_i;
          need_q      <= need_rnd;
          addr_q      <= req_address_i;
          k_q         <= '0;
          lo_end_q    <= {1'b0, bottom_q};
          found_q     <= 1'b0;
          best_gap_q  <= '0;
          best_base_q <= '0;
          ok_q        <= 1'b0;
          grant_q     <= '0;
        end
        OpScan: begin
          if (type_q == ReqFree) begin
            if (in_table && cur_start == addr_q) found_q <= 1'b1;
            else k_q <= k_q + CntW'(1);
          end else if (!sts_o.fail_early) begin
            if (fits) begin
              found_q     <= 1'b1;
              best_gap_q  <= gap;
              best_base_q <= lo_end_q;
            end
            lo_end_q <= {1'b0, cur_start} + {1'b0, cur_len};
            if (!sts_o.scan_last) k_q <= k_q + CntW'(1);
          end
        end
        OpPlace: begin
          if (found_q) begin
            if (type_q == ReqFree) begin
              ok_q <= 1'b1;
            end else begin
              addr_q  <= place[31:0];
              grant_q <= place[31:0];
              ok_q    <= 1'b1;
              k_q     <= count_q;
            end
          end
        end
        OpShift: begin
          if (type_q == ReqFree) begin
            if (k_q + CntW'(1) < count_q) begin
              start_q[k_idx] <= start_q[kp1_idx];
              len_q[k_idx]   <= len_q[kp1_idx];
              k_q <= k_q + CntW'(1);
            end else begin
              count_q <= count_q - CntW'(1);
            end
          end else begin
            // Shift up while the lower neighbour starts above the new block
            if (k_q != '0 && start_q[km1_idx] > addr_q) begin
              start_q[k_idx] <= start_q[km1_idx];
              len_q[k_idx]   <= len_q[km1_idx];
              k_q   <= k_q - CntW'(1);
            end else begin
              start_q[k_idx] <= addr_q;
              len_q[k_idx]   <= need_q[31:0];
              count_q <= count_q + CntW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign grant_address_o = grant_q;
  assign success_o       = ok_q;
endmodule
`default_nettype wire

### rtl/best_fit_region_allocator.sv
// Top level of the best-fit region allocator
// Keeps a sorted table of up to 14 allocated regions in the window set by
// heap_bottom and heap_top. One request is worked at a time: an allocate
// scans count+1 gaps one per cycle, then inserts by moving entries one per
// cycle; a free scans to the matching entry and closes the hole one entry
// per cycle. Each request is sequenced by the single-entry scan and shift
// sequencer. The result is held in an output register until taken.
`default_nettype none
module best_fit_region_allocator (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire         cfg_index_i,
  input  wire [31:0]  cfg_data_i,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [71:0]  s_axis_tdata,   // req_type[1:0], req_size[33:2], req_address[65:34]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata    // grant_address[31:0], success[32]
);
  import bfra_pkg::*;

  bfra_cmd_t   cmd;
  bfra_sts_t   sts;
  logic [31:0] grant;
  logic        ok;

  assign cfg_ready_o = 1'b1;

  bfra_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bfra_dp u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (s_axis_tdata[1:0]),
    .req_size_i      (s_axis_tdata[33:2]),
    .req_address_i   (s_axis_tdata[65:34]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .grant_address_o (grant),
    .success_o       (ok)
  );

  assign m_axis_tdata = {7'd0, ok, grant};
endmodule
`default_nettype wire

### rtl/bfra_checker.sv
// Port-level checker for the allocator, bound to the top level
`default_nettype none
`include "best_fit_region_allocator_assert.svh"
module bfra_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [39:0] m_axis_tdata
);
  `BFRA_ASSERT_NEXT(a_res_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `BFRA_ASSERT_IMPL(a_fail_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[32], m_axis_tdata[31:0] == 32'd0)
  `BFRA_ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  `BFRA_ASSERT_NEXT(a_no_instant_res, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !m_axis_tvalid)
endmodule
bind best_fit_region_allocator bfra_checker u_bfra_checker (.*);
`default_nettype wire
